// ===== design/mpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the max pooling with argmax block.
// No dependencies; imported by mpa_front, mpa_back and the top level.
package mpa_pkg;

  localparam int IDX_W   = 28;  // flat input index
  localparam int ROW_W   = 10;  // row counter, rows below 1024
  localparam int PLANE_W = 8;   // channel counter, planes below 256
  localparam int DIM_W   = 13;  // effective width, holds up to 8191
  localparam int PEFF_W  = 7;   // effective pool size, holds up to 127

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int WIDTH_REG_W    = 11;
  localparam int HEIGHT_REG_W   = 11;
  localparam int CHANNEL_REG_W  = 9;
  localparam int POOL_REG_W     = 5;

  localparam logic [WIDTH_REG_W-1:0]   WIDTH_RESET    = 11'd32;
  localparam logic [HEIGHT_REG_W-1:0]  HEIGHT_RESET   = 11'd32;
  localparam logic [CHANNEL_REG_W-1:0] CHANNEL_RESET  = 9'd1;
  localparam logic [POOL_REG_W-1:0]    POOL_RESET     = 5'd2;

  localparam logic [HEIGHT_REG_W-1:0]  HEIGHT_MAX     = 11'd1024;
  localparam logic [CHANNEL_REG_W-1:0] CHANNEL_MAX    = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_POOL_SIZE     = 2'd3
  } mpa_reg_e;

  // Per-pixel classification handed from the front end to the back end.
  typedef struct packed {
    logic first;       // opens a window
    logic last;        // closes a window, a result follows
    logic frame_last;  // closes the final full window of the frame
  } mpa_flags_t;

  localparam int FLAGS_W = $bits(mpa_flags_t);

endpackage

// ===== design/mpa_fifo.sv =====
`timescale 1ns / 1ps
// Small register FIFO, used between front and back end and as the result queue.
// Depends on nothing.
module mpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/mpa_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters and per-pixel
// classification (window slot, first/last, frame end). Uses mpa_pkg.
module mpa_front
  import mpa_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 16,
  parameter int DATA_BITS = 16,
  parameter int SLOT_W    = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        accept_i,
  input  logic signed [DATA_BITS-1:0] pixel_i,
  output logic [SLOT_W-1:0]           slot_o,
  output logic signed [DATA_BITS-1:0] pixel_o,
  output logic [IDX_W-1:0]            index_o,
  output mpa_flags_t                  flags_o
);

  localparam int POOL_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

  logic [WIDTH_REG_W-1:0]   width_q;
  logic [HEIGHT_REG_W-1:0]  height_q;
  logic [CHANNEL_REG_W-1:0] channels_q;
  logic [POOL_REG_W-1:0]    pool_q;

  logic [SLOT_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [IDX_W-1:0]   flat_q, flat_d;
  logic [POOL_W-1:0]  win_col_q, win_col_d;
  logic [POOL_W-1:0]  win_row_q, win_row_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  logic [DIM_W-1:0]         w_eff;
  logic [HEIGHT_REG_W-1:0]  h_eff;
  logic [CHANNEL_REG_W-1:0] c_eff;
  logic [PEFF_W-1:0]        p_eff;
  logic                     cfg_write;
  logic                     col_end, row_end, plane_end;
  logic                     wc_end, wr_end;
  logic                     right_done, bottom_done;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      channels_q <= CHANNEL_RESET;
      pool_q     <= POOL_RESET;
    end else if (cfg_write) begin
      unique case (mpa_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   width_q    <= cfg_data_i;
        REG_IMAGE_HEIGHT:  height_q   <= cfg_data_i;
        REG_CHANNEL_COUNT: channels_q <= cfg_data_i[CHANNEL_REG_W-1:0];
        REG_POOL_SIZE:     pool_q     <= cfg_data_i[POOL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into their legal span.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
    if (channels_q == '0) begin
      c_eff = CHANNEL_REG_W'(1);
    end else if (channels_q > CHANNEL_MAX) begin
      c_eff = CHANNEL_MAX;
    end else begin
      c_eff = channels_q;
    end
    if (pool_q == '0) begin
      p_eff = PEFF_W'(1);
    end else if (PEFF_W'(pool_q) > PEFF_W'(MAX_POOL)) begin
      p_eff = PEFF_W'(MAX_POOL);
    end else begin
      p_eff = PEFF_W'(pool_q);
    end
  end

  assign col_end   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
  assign row_end   = (HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1)) >= h_eff;
  assign plane_end = (CHANNEL_REG_W'(plane_q) + CHANNEL_REG_W'(1)) >= c_eff;
  assign wc_end    = (PEFF_W'(win_col_q) + PEFF_W'(1)) == p_eff;
  assign wr_end    = (PEFF_W'(win_row_q) + PEFF_W'(1)) == p_eff;

  // On a closing pixel col+1 is a multiple of the pool; it is the last full
  // window of the row when another whole window no longer fits.
  assign right_done  = (DIM_W'(col_q) + DIM_W'(1) + DIM_W'(p_eff)) > w_eff;
  assign bottom_done = (DIM_W'(row_q) + DIM_W'(1) + DIM_W'(p_eff)) > DIM_W'(h_eff);

  always_comb begin
    flags_o.first      = (win_col_q == '0) && (win_row_q == '0);
    flags_o.last       = wc_end && wr_end;
    flags_o.frame_last = wc_end && wr_end && plane_end && right_done && bottom_done;
  end

  assign slot_o  = slot_q;
  assign pixel_o = pixel_i;
  assign index_o = flat_q;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    plane_d   = plane_q;
    flat_d    = flat_q;
    win_col_d = win_col_q;
    win_row_d = win_row_q;
    slot_d    = slot_q;
    if (cfg_write) begin
      col_d     = '0;
      row_d     = '0;
      plane_d   = '0;
      flat_d    = '0;
      win_col_d = '0;
      win_row_d = '0;
      slot_d    = '0;
    end else if (accept_i) begin
      flat_d = flat_q + 1'b1;
      if (col_end) begin
        col_d     = '0;
        win_col_d = '0;
        slot_d    = '0;
        if (row_end) begin
          row_d     = '0;
          win_row_d = '0;
          if (plane_end) begin
            plane_d = '0;
            flat_d  = '0;
          end else begin
            plane_d = plane_q + 1'b1;
          end
        end else begin
          row_d     = row_q + 1'b1;
          win_row_d = wr_end ? '0 : win_row_q + 1'b1;
        end
      end else begin
        col_d     = col_q + 1'b1;
        win_col_d = wc_end ? '0 : win_col_q + 1'b1;
        slot_d    = wc_end ? slot_q + 1'b1 : slot_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      plane_q   <= '0;
      flat_q    <= '0;
      win_col_q <= '0;
      win_row_q <= '0;
      slot_q    <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      plane_q   <= plane_d;
      flat_q    <= flat_d;
      win_col_q <= win_col_d;
      win_row_q <= win_row_d;
      slot_q    <= slot_d;
    end
  end

endmodule

// ===== design/mpa_back.sv =====
`timescale 1ns / 1ps
// Back end: line store of running window maxima, two-stage read/update pipe
// with forwarding, and result generation. Uses mpa_pkg.
module mpa_back
  import mpa_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int DATA_BITS = 16,
  parameter int SLOT_W    = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  logic [SLOT_W-1:0]           q_slot_i,
  input  logic signed [DATA_BITS-1:0] q_pixel_i,
  input  logic [IDX_W-1:0]            q_index_i,
  input  mpa_flags_t                  q_flags_i,
  output logic                        q_pop_o,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic signed [DATA_BITS-1:0] res_value_o,
  output logic [IDX_W-1:0]            res_index_o,
  output logic                        res_last_o
);

  localparam int ENTRY_W = DATA_BITS + IDX_W;

  logic [ENTRY_W-1:0] store_q [MAX_WIDTH];
  logic [ENTRY_W-1:0] rd_q;

  // read stage
  logic                        s1_valid_q;
  logic [SLOT_W-1:0]           s1_slot_q;
  logic signed [DATA_BITS-1:0] s1_pix_q;
  logic [IDX_W-1:0]            s1_idx_q;
  mpa_flags_t                  s1_flags_q;
  logic                        fwd_q;
  logic signed [DATA_BITS-1:0] fwd_val_q;
  logic [IDX_W-1:0]            fwd_idx_q;

  // update stage
  logic                        s2_valid_q;
  logic [SLOT_W-1:0]           s2_slot_q;
  logic signed [DATA_BITS-1:0] s2_pix_q;
  logic [IDX_W-1:0]            s2_idx_q;
  mpa_flags_t                  s2_flags_q;
  logic signed [DATA_BITS-1:0] s2_old_val_q;
  logic [IDX_W-1:0]            s2_old_idx_q;

  logic                        adv;
  logic                        take;
  logic signed [DATA_BITS-1:0] s2_new_val;
  logic [IDX_W-1:0]            s2_new_idx;
  logic                        hit2;
  logic signed [DATA_BITS-1:0] s1_old_val;
  logic [IDX_W-1:0]            s1_old_idx;

  // Whole pipe moves unless a closing pixel has nowhere to put its result.
  assign adv     = !(s2_valid_q && s2_flags_q.last && res_full_i);
  assign q_pop_o = adv && q_valid_i;

  assign take       = s2_flags_q.first || (s2_pix_q > s2_old_val_q);
  assign s2_new_val = take ? s2_pix_q : s2_old_val_q;
  assign s2_new_idx = take ? s2_idx_q : s2_old_idx_q;

  // The store read misses the writes of the two pixels ahead: the one in the
  // update stage now, and the one that was written in the cycle of the read.
  assign hit2 = s2_valid_q && (s2_slot_q == s1_slot_q);
  always_comb begin
    if (hit2) begin
      s1_old_val = s2_new_val;
      s1_old_idx = s2_new_idx;
    end else if (fwd_q) begin
      s1_old_val = fwd_val_q;
      s1_old_idx = fwd_idx_q;
    end else begin
      s1_old_val = rd_q[ENTRY_W-1:IDX_W];
      s1_old_idx = rd_q[IDX_W-1:0];
    end
  end

  assign res_push_o  = adv && s2_valid_q && s2_flags_q.last;
  assign res_value_o = s2_new_val;
  assign res_index_o = s2_new_idx;
  assign res_last_o  = s2_flags_q.frame_last;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= store_q[q_slot_i];
      if (s2_valid_q) begin
        store_q[s2_slot_q] <= {s2_new_val, s2_new_idx};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
      fwd_q      <= s2_valid_q && (s2_slot_q == q_slot_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_slot_q    <= q_slot_i;
      s1_pix_q     <= q_pixel_i;
      s1_idx_q     <= q_index_i;
      s1_flags_q   <= q_flags_i;
      fwd_val_q    <= s2_new_val;
      fwd_idx_q    <= s2_new_idx;
      s2_slot_q    <= s1_slot_q;
      s2_pix_q     <= s1_pix_q;
      s2_idx_q     <= s1_idx_q;
      s2_flags_q   <= s1_flags_q;
      s2_old_val_q <= s1_old_val;
      s2_old_idx_q <= s1_old_idx;
    end
  end

`ifndef SYNTHESIS
  a_no_result_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pixel queue popped while empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> (s2_valid_q && $stable(s2_slot_q) && $stable(s2_idx_q)))
    else $error("update stage changed while stalled");

  a_frame_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_flags_q.frame_last) |-> s2_flags_q.last)
    else $error("frame end on a pixel that closes no window");
`endif

endmodule

// ===== design/max_pool_with_argmax_core.sv =====
`timescale 1ns / 1ps
// Top level of streaming 2-D max pooling with argmax.
// Instantiates mpa_front, mpa_fifo (twice) and mpa_back; uses mpa_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   pixels   | push / full           | pixel_value_i
//   results  | pop / empty           | pooled_value_o, max_position_o, frame_last_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per clock sustained unless a full result queue stalls the back end.
// A result passes the pixel queue, store read, update stage and result queue.
// The line store has one write and one registered read port; back-to-back
// pixels of one window are served by forwarding from the update stage.
// Reset clears counters, queues and pipe valids; the store needs no clearing.
// A full result queue stalls the back end once a result is due; the pixel queue then fills and raises full.
module max_pool_with_argmax_core
  import mpa_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic signed [DATA_BITS-1:0] pixel_value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [DATA_BITS-1:0] pooled_value_o,
  output logic [IDX_W-1:0]            max_position_o,
  output logic                        frame_last_o
);

  localparam int SLOT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ITEM_W  = SLOT_W + DATA_BITS + IDX_W + FLAGS_W;
  localparam int RES_W   = DATA_BITS + IDX_W + 1;
  localparam int ITEM_DEPTH = 4;
  localparam int RES_DEPTH  = 2;

  logic                        accept;
  logic [SLOT_W-1:0]           f_slot;
  logic signed [DATA_BITS-1:0] f_pixel;
  logic [IDX_W-1:0]            f_index;
  mpa_flags_t                  f_flags;

  logic [ITEM_W-1:0]           q_data;
  logic                        q_empty;
  logic                        q_pop;
  logic [SLOT_W-1:0]           q_slot;
  logic signed [DATA_BITS-1:0] q_pixel;
  logic [IDX_W-1:0]            q_index;
  mpa_flags_t                  q_flags;

  logic                        res_push;
  logic                        res_full;
  logic signed [DATA_BITS-1:0] res_value;
  logic [IDX_W-1:0]            res_index;
  logic                        res_last;
  logic [RES_W-1:0]            res_data;

  assign accept = push && !full;

  mpa_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POOL  (MAX_POOL),
    .DATA_BITS (DATA_BITS),
    .SLOT_W    (SLOT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     (pixel_value_i),
    .slot_o      (f_slot),
    .pixel_o     (f_pixel),
    .index_o     (f_index),
    .flags_o     (f_flags)
  );

  mpa_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  ({f_slot, f_pixel, f_index, f_flags}),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign {q_slot, q_pixel, q_index, q_flags} = q_data;

  mpa_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .DATA_BITS (DATA_BITS),
    .SLOT_W    (SLOT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_slot_i    (q_slot),
    .q_pixel_i   (q_pixel),
    .q_index_i   (q_index),
    .q_flags_i   (q_flags),
    .q_pop_o     (q_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_value_o (res_value),
    .res_index_o (res_index),
    .res_last_o  (res_last)
  );

  mpa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  ({res_value, res_index, res_last}),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign {pooled_value_o, max_position_o, frame_last_o} = res_data;

endmodule
